// ----- rtl/rgc_pkg.sv -----
// Package for the RGB gamma correction block: widths, defaults and the
// elaboration-time functions that build the log and root tables.
// No dependencies.
`default_nettype none
package rgc_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int GAMMA_W          = 16;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd4096;
  localparam int FRAC_BITS        = 28;
  localparam int D_W              = 32;   // log distance, unsigned Q4.28
  localparam int P_W              = 36;   // d * gamma >> 12, unsigned Q8.28
  localparam int K_W              = P_W - FRAC_BITS;
  localparam int Y_W              = 31;   // Q1.30, never above 1.0
  localparam int T_W              = 30;   // root factors, below 1.0
  localparam int OUT_BIAS_SHIFT   = 20;

  // Integer square root, bit by bit.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    rem  = v;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bitv > rem) bitv = bitv >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // Factor 2^(-2^-i) in Q.30, built by repeated square roots.
  function automatic logic [T_W-1:0] root_q30(input int i);
    logic [63:0] t;
    t = isqrt64(64'd1 << 59);
    for (int j = 2; j <= FRAC_BITS; j++) begin
      if (j <= i) t = isqrt64(t << 30);
    end
    return t[T_W-1:0];
  endfunction

  // log2 of x (x >= 1) in unsigned Q.28, fraction by repeated squaring.
  function automatic logic [D_W-1:0] log2_q28(input logic [31:0] x);
    logic [63:0] m;
    logic [FRAC_BITS-1:0] frac;
    int e;
    e    = 0;
    frac = '0;
    for (int j = 0; j < 32; j++) begin
      if ((x >> j) > 1) e = j + 1;
    end
    m = 64'(x) << (30 - e);
    for (int j = 0; j < FRAC_BITS; j++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        frac[0] = 1'b1;
        m       = m >> 1;
      end
    end
    return D_W'((64'(e) << FRAC_BITS) | 64'(frac));
  endfunction

  // Distance log2(max) - log2(x); zero input has no log and maps to zero.
  function automatic logic [D_W-1:0] log_dist(input int x, input int cbits);
    logic [31:0] mx;
    mx = (32'd1 << cbits) - 32'd1;
    if (x == 0) return '0;
    return log2_q28(mx) - log2_q28(32'(x));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rgc_lane.sv -----
// One color channel of the gamma pipeline: log lookup, gamma multiply,
// 28 root-factor stages and final scale. Depends on rgc_pkg.
`default_nettype none
module rgc_lane
  import rgc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire                     clk,
  input  wire                     en,
  input  wire  [CHANNEL_BITS-1:0] x_in,
  input  wire  [GAMMA_W-1:0]      gamma,
  output logic [CHANNEL_BITS-1:0] y_out
);

  localparam int NX = 1 << CHANNEL_BITS;
  localparam logic [CHANNEL_BITS-1:0] MAXV = {CHANNEL_BITS{1'b1}};

  typedef struct packed {
    logic zero;
    logic full;
    logic gzero;
  } flags_t;

  logic [D_W-1:0] dtab [NX];
  for (genvar g = 0; g < NX; g++) begin : g_tab
    localparam logic [D_W-1:0] DV = log_dist(g, CHANNEL_BITS);
    assign dtab[g] = DV;
  end

  // Stage 0: table lookup.
  logic [D_W-1:0] d_r;
  flags_t         f0_r;
  // Stage 1: two partial products of d * gamma.
  logic [31:0]    pplo_r, pphi_r;
  flags_t         f1_r;
  // Stage 2: exponent split into integer and fraction.
  logic [K_W-1:0]       k_r  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] fr_r [FRAC_BITS+1];
  logic [Y_W-1:0]       y_r  [FRAC_BITS+1];
  flags_t               fl_r [FRAC_BITS+1];
  // Final two stages.
  logic [Y_W-1:0] ys_r;
  flags_t         fs_r;
  logic [CHANNEL_BITS-1:0] out_r;

  // The full product d * gamma, before the shift by 12.
  logic [P_W+12-1:0] psum;
  assign psum = (P_W+12)'(pplo_r) + ((P_W+12)'(pphi_r) << 16);

  always_ff @(posedge clk) begin
    if (en) begin
      d_r        <= dtab[x_in];
      f0_r.zero  <= (x_in == '0);
      f0_r.full  <= (x_in == MAXV);
      f0_r.gzero <= (gamma == '0);
      pplo_r     <= 32'(d_r[15:0]) * 32'(gamma);
      pphi_r     <= 32'(d_r[31:16]) * 32'(gamma);
      f1_r       <= f0_r;
      k_r[0]     <= psum[P_W+12-1:FRAC_BITS+12];
      fr_r[0]    <= psum[FRAC_BITS+12-1:12];
      y_r[0]     <= Y_W'(1) << 30;
      fl_r[0]    <= f1_r;
    end
  end

  for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_root
    localparam logic [T_W-1:0] TV = root_q30(i);
    logic [Y_W+T_W-1:0] prod;
    assign prod = (Y_W+T_W)'(y_r[i-1]) * (Y_W+T_W)'(TV);
    always_ff @(posedge clk) begin
      if (en) begin
        y_r[i]  <= fr_r[i-1][FRAC_BITS-i] ? prod[Y_W+30-1:30] : y_r[i-1];
        k_r[i]  <= k_r[i-1];
        fr_r[i] <= fr_r[i-1];
        fl_r[i] <= fl_r[i-1];
      end
    end
  end

  logic [Y_W+CHANNEL_BITS-1:0] scaled;
  logic [Y_W+CHANNEL_BITS-1:0] rounded;
  logic [Y_W+CHANNEL_BITS-31:0] top;
  assign scaled  = (Y_W+CHANNEL_BITS)'(ys_r) * (Y_W+CHANNEL_BITS)'(MAXV);
  assign rounded = scaled + ((Y_W+CHANNEL_BITS)'(1) << OUT_BIAS_SHIFT);
  assign top     = rounded[Y_W+CHANNEL_BITS-1:30];

  always_ff @(posedge clk) begin
    if (en) begin
      if (k_r[FRAC_BITS] >= K_W'(31)) ys_r <= '0;
      else ys_r <= y_r[FRAC_BITS] >> k_r[FRAC_BITS];
      fs_r <= fl_r[FRAC_BITS];
      if (fs_r.zero) out_r <= fs_r.gzero ? MAXV : '0;
      else if (fs_r.full) out_r <= MAXV;
      else if (top > (Y_W+CHANNEL_BITS-30)'(MAXV)) out_r <= MAXV;
      else out_r <= top[CHANNEL_BITS-1:0];
    end
  end

  assign y_out = out_r;

endmodule
`default_nettype wire

// ----- rtl/rgb_gamma_correction.sv -----
// Throughput: one pixel per cycle; the 28 root-factor multiply stages per
// channel are fully pipelined, and a stall at the output holds every stage.
// Reset (rst_n low, synchronous) clears all valid bits and sets gamma to 1.0.
// Top level of the RGB gamma corrector; depends on rgc_pkg and rgc_lane.
`default_nettype none
module rgb_gamma_correction
  import rgc_pkg::*;
#(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [GAMMA_W-1:0]                    cfg_wdata,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // red_in, green_in, blue_in from bit 0 up, zero padded
  input  wire  [((3*CHANNEL_BITS+7)/8)*8-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // red_out, green_out, blue_out from bit 0 up, zero padded
  output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]   out_tdata
);

  localparam int TW  = ((3*CHANNEL_BITS+7)/8)*8;
  localparam int LAT = FRAC_BITS + 5;

  logic [GAMMA_W-1:0] gamma_r;
  logic [LAT-1:0]     vld_r;
  logic               en;
  logic [CHANNEL_BITS-1:0] res [3];

  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en && rst_n;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RESET;
      vld_r   <= '0;
    end else begin
      if (cfg_we) gamma_r <= cfg_wdata;
      if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    rgc_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane (
      .clk   (clk),
      .en    (en),
      .x_in  (in_tdata[c*CHANNEL_BITS +: CHANNEL_BITS]),
      .gamma (gamma_r),
      .y_out (res[c])
    );
  end

  assign out_tdata = TW'({res[2], res[1], res[0]});

`ifndef NO_ASSERTIONS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("pipeline stalls with empty output");
  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid) else $error("valid survives reset");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(vld_r))
    else $error("pipeline moved during output stall");
`endif

endmodule
`default_nettype wire
